/* hw/rtl/lpfd_pkg.sv */
// ----------------------------------------------------------------------------
// lpfd_pkg
// Shared types and constants for the length-prefixed frame deframer.
// ----------------------------------------------------------------------------
`default_nettype none

package lpfd_pkg;

   localparam int unsigned HDR_BYTES         = 20;
   localparam int unsigned HDR_CNT_W         = 5;
   localparam int unsigned LEN_W             = 25;
   localparam int unsigned HARD_MAX_BODY_DEF = 16 * 1024 * 1024;
   localparam int unsigned DEFAULT_MAX_BODY  = 1024 * 1024;

   localparam logic [31:0] FRAME_MAGIC   = 32'h4D43_4854;
   localparam logic [7:0]  FRAME_VERSION = 8'd2;
   localparam logic [15:0] HDR_LEN_FIELD = 16'(HDR_BYTES);

   typedef enum logic [1:0] {
      PH_HEADER = 2'd0,
      PH_BODY   = 2'd1,
      PH_DROP   = 2'd2
   } phase_type;

   typedef enum logic [1:0] {
      KIND_HEADER = 2'd0,
      KIND_BODY   = 2'd1,
      KIND_ERROR  = 2'd2
   } kind_type;

   typedef enum logic [1:0] {
      ERR_NONE     = 2'd0,
      ERR_PROTOCOL = 2'd1,
      ERR_VERSION  = 2'd2
   } err_type;

   typedef struct packed {
      logic             done;
      logic             fail;
      err_type          err_code;
      logic [15:0]      message_type;
      logic [7:0]       content_type;
      logic [31:0]      request_id;
      logic [LEN_W-1:0] body_length;
   } hdr_res_type;

   typedef struct packed {
      kind_type         kind;
      err_type          error_code;
      logic [15:0]      message_type;
      logic [7:0]       content_type;
      logic [31:0]      request_id;
      logic [LEN_W-1:0] body_length;
      logic [7:0]       body_byte;
      logic             last;
   } rsp_word_type;

endpackage

`default_nettype wire

/* hw/rtl/lpfd_req_if.sv */
// ----------------------------------------------------------------------------
// lpfd_req_if
// Byte stream channel into the deframer, valid/ready.
// ----------------------------------------------------------------------------
`default_nettype none

interface lpfd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;

   modport source (output valid, output data_byte, input ready);
   modport sink   (input valid, input data_byte, output ready);
endinterface

`default_nettype wire

/* hw/rtl/lpfd_rsp_if.sv */
// ----------------------------------------------------------------------------
// lpfd_rsp_if
// Result channel out of the deframer, valid/ready.
// ----------------------------------------------------------------------------
`default_nettype none

interface lpfd_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  kind;
   logic [1:0]  error_code;
   logic [15:0] message_type;
   logic [7:0]  content_type;
   logic [31:0] request_id;
   logic [24:0] body_length;
   logic [7:0]  body_byte;
   logic        last;

   modport source (output valid, output kind, output error_code, output message_type,
                   output content_type, output request_id, output body_length,
                   output body_byte, output last, input ready);
   modport sink   (input valid, input kind, input error_code, input message_type,
                   input content_type, input request_id, input body_length,
                   input body_byte, input last, output ready);
endinterface

`default_nettype wire

/* hw/rtl/lpfd_csr.sv */
// ----------------------------------------------------------------------------
// lpfd_csr
// Body length limit register, clamped to the hard maximum on write and reset.
// ----------------------------------------------------------------------------
`default_nettype none

module lpfd_csr #(
   parameter int unsigned HARD_MAX_BODY = lpfd_pkg::HARD_MAX_BODY_DEF
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       csr_wr_en,
   input  wire logic [lpfd_pkg::LEN_W-1:0] csr_wr_data,
   output logic      [lpfd_pkg::LEN_W-1:0] max_body_length
);
   import lpfd_pkg::*;

   localparam logic [LEN_W-1:0] HARD_MAX  = LEN_W'(HARD_MAX_BODY);
   localparam logic [LEN_W-1:0] RESET_MAX =
      (DEFAULT_MAX_BODY > HARD_MAX_BODY) ? HARD_MAX : LEN_W'(DEFAULT_MAX_BODY);

   logic [LEN_W-1:0] max_ff;
   logic [LEN_W-1:0] max_in;

   assign max_in = (csr_wr_data > HARD_MAX) ? HARD_MAX : csr_wr_data;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_ff <= RESET_MAX;
      end else if (csr_wr_en) begin
         max_ff <= max_in;
      end
   end

   assign max_body_length = max_ff;

endmodule

`default_nettype wire

/* hw/rtl/lpfd_hdr_unit.sv */
// ----------------------------------------------------------------------------
// lpfd_hdr_unit
// Collects header bytes in a shift line and checks the header when its
// final byte arrives.
// ----------------------------------------------------------------------------
`default_nettype none

module lpfd_hdr_unit (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       step,
   input  wire logic [7:0]                 data_byte,
   input  wire logic [lpfd_pkg::LEN_W-1:0] max_body_length,
   output lpfd_pkg::hdr_res_type           res
);
   import lpfd_pkg::*;

   localparam int unsigned SHIFT_LEN = HDR_BYTES - 1;

   logic [7:0]           hdr_ff [0:SHIFT_LEN-1];
   logic [HDR_CNT_W-1:0] count_ff;
   logic [HDR_CNT_W-1:0] count_in;
   logic                 last_byte;

   logic [31:0] magic;
   logic [15:0] hlen;
   logic [31:0] blen;
   err_type     err;

   assign last_byte = (count_ff == HDR_CNT_W'(SHIFT_LEN));
   assign count_in  = last_byte ? '0 : count_ff + HDR_CNT_W'(1);

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (step) begin
         count_ff <= count_in;
      end
   end

   // byte k of the header sits in hdr_ff[k] once the first 19 have gone in
   always_ff @(posedge clock) begin
      if (step) begin
         for (int i = 0; i < SHIFT_LEN - 1; i++) begin
            hdr_ff[i] <= hdr_ff[i+1];
         end
         hdr_ff[SHIFT_LEN-1] <= data_byte;
      end
   end

   assign magic = {hdr_ff[0], hdr_ff[1], hdr_ff[2], hdr_ff[3]};
   assign hlen  = {hdr_ff[6], hdr_ff[7]};
   assign blen  = {hdr_ff[8], hdr_ff[9], hdr_ff[10], hdr_ff[11]};

   always_comb begin
      priority if (magic != FRAME_MAGIC) begin
         err = ERR_PROTOCOL;
      end else if (hdr_ff[4] != FRAME_VERSION) begin
         err = ERR_VERSION;
      end else if (hlen != HDR_LEN_FIELD) begin
         err = ERR_PROTOCOL;
      end else if (hdr_ff[5] != 8'd0) begin
         err = ERR_PROTOCOL;
      end else if (hdr_ff[15] != 8'd0) begin
         err = ERR_PROTOCOL;
      end else if (blen > 32'(max_body_length)) begin
         err = ERR_PROTOCOL;
      end else begin
         err = ERR_NONE;
      end
   end

   always_comb begin
      res.done         = step && last_byte;
      res.fail         = (err != ERR_NONE);
      res.err_code     = err;
      res.message_type = {hdr_ff[12], hdr_ff[13]};
      res.content_type = hdr_ff[14];
      res.request_id   = {hdr_ff[16], hdr_ff[17], hdr_ff[18], data_byte};
      res.body_length  = blen[LEN_W-1:0];
   end

endmodule

`default_nettype wire

/* hw/rtl/length_prefixed_frame_deframer.sv */
// ----------------------------------------------------------------------------
// length_prefixed_frame_deframer
// Splits a byte stream into a checked 20-byte header result and body byte
// results; a failing header gives one error result, and every later byte is dropped.
// ----------------------------------------------------------------------------
// Throughput: one byte per cycle while the result channel is not stalled.
// An accepted byte goes from the input register on to the result register.
// A waiting result stalls the input stage once that stage holds a byte.
// Reset: pipeline empty, header phase, limit = min(1 MiB, HARD_MAX_BODY).
// ----------------------------------------------------------------------------
`default_nettype none

module length_prefixed_frame_deframer #(
   parameter int unsigned HARD_MAX_BODY = lpfd_pkg::HARD_MAX_BODY_DEF
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   lpfd_req_if.sink                        req,
   lpfd_rsp_if.source                      rsp,
   input  wire logic                       csr_wr_en,
   input  wire logic [lpfd_pkg::LEN_W-1:0] csr_wr_data
);
   import lpfd_pkg::*;

   logic             in_valid_ff;
   logic [7:0]       in_byte_ff;
   logic             advance;
   logic             take;

   phase_type        phase_ff;
   phase_type        phase_in;
   logic [LEN_W-1:0] rem_ff;
   logic [LEN_W-1:0] rem_in;
   logic [LEN_W-1:0] rem_dec;

   logic             rsp_valid_ff;
   rsp_word_type     rsp_ff;
   rsp_word_type     out_in;
   logic             out_load;

   logic [LEN_W-1:0] max_body_length;
   hdr_res_type      hres;

   lpfd_csr #(
      .HARD_MAX_BODY (HARD_MAX_BODY)
   ) u_csr (
      .clock           (clock),
      .reset           (reset),
      .csr_wr_en       (csr_wr_en),
      .csr_wr_data     (csr_wr_data),
      .max_body_length (max_body_length)
   );

   lpfd_hdr_unit u_hdr (
      .clock           (clock),
      .reset           (reset),
      .step            (take && (phase_ff == PH_HEADER)),
      .data_byte       (in_byte_ff),
      .max_body_length (max_body_length),
      .res             (hres)
   );

   assign advance   = !rsp_valid_ff || rsp.ready;
   assign take      = in_valid_ff && advance;
   assign req.ready = !in_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req.ready) begin
         in_valid_ff <= req.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req.valid && req.ready) begin
         in_byte_ff <= req.data_byte;
      end
   end

   assign rem_dec = (rem_ff != '0) ? rem_ff - LEN_W'(1) : rem_ff;

   always_comb begin
      phase_in = phase_ff;
      rem_in   = rem_ff;
      out_load = 1'b0;
      out_in   = '0;
      unique case (phase_ff)
         PH_HEADER: begin
            if (hres.done) begin
               out_load = 1'b1;
               if (hres.fail) begin
                  phase_in          = PH_DROP;
                  out_in.kind       = KIND_ERROR;
                  out_in.error_code = hres.err_code;
                  out_in.last       = 1'b1;
               end else begin
                  out_in.kind         = KIND_HEADER;
                  out_in.error_code   = ERR_NONE;
                  out_in.message_type = hres.message_type;
                  out_in.content_type = hres.content_type;
                  out_in.request_id   = hres.request_id;
                  out_in.body_length  = hres.body_length;
                  if (hres.body_length == '0) begin
                     out_in.last = 1'b1;
                  end else begin
                     rem_in   = hres.body_length;
                     phase_in = PH_BODY;
                  end
               end
            end
         end
         PH_BODY: begin
            if (take) begin
               out_load         = 1'b1;
               out_in.kind      = KIND_BODY;
               out_in.body_byte = in_byte_ff;
               rem_in           = rem_dec;
               if (rem_dec == '0) begin
                  out_in.last = 1'b1;
                  phase_in    = PH_HEADER;
               end
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_HEADER;
         rem_ff   <= '0;
      end else begin
         phase_ff <= phase_in;
         rem_ff   <= rem_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= out_load;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_ff <= out_in;
      end
   end

   assign rsp.valid        = rsp_valid_ff;
   assign rsp.kind         = rsp_ff.kind;
   assign rsp.error_code   = rsp_ff.error_code;
   assign rsp.message_type = rsp_ff.message_type;
   assign rsp.content_type = rsp_ff.content_type;
   assign rsp.request_id   = rsp_ff.request_id;
   assign rsp.body_length  = rsp_ff.body_length;
   assign rsp.body_byte    = rsp_ff.body_byte;
   assign rsp.last         = rsp_ff.last;

   ap_drop_sticky: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_DROP |=> phase_ff == PH_DROP)
      else $error("left drop phase");

   ap_body_count: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_BODY |-> rem_ff != '0)
      else $error("body phase with nothing left");

   ap_error_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.kind == KIND_ERROR |->
         rsp_ff.last && rsp_ff.error_code != ERR_NONE)
      else $error("error result without last or code");

   ap_error_drops: assert property (@(posedge clock) disable iff (reset)
      out_load && out_in.kind == KIND_ERROR |=> phase_ff == PH_DROP)
      else $error("error result did not enter drop phase");

endmodule

`default_nettype wire

/* bench/length_prefixed_frame_deframer_tb.sv */
// ----------------------------------------------------------------------------
// length_prefixed_frame_deframer_tb
// Streams framed bytes into the deframer with random gaps on both channels.
// Every result word is checked against a byte-level model of the header
// checks and the body count. The run steps through several body limits,
// from zero to values above the hard cap. It closes with one bad header,
// after which the stream must stay silent.
// ----------------------------------------------------------------------------
module length_prefixed_frame_deframer_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import lpfd_pkg::*;

   localparam int unsigned CYCLE_LIMIT  = 400_000;
   localparam int unsigned DRAIN_CYCLES = 6;
   localparam int unsigned RANDOM_BYTES = 560;
   localparam int unsigned NUM_PHASES   = 7;
   localparam int unsigned REPORT_MAX   = 10;
   localparam logic [LEN_W-1:0] HARD_LIMIT = LEN_W'(HARD_MAX_BODY_DEF);

   typedef struct packed {
      logic [31:0] magic;
      logic [7:0]  version;
      logic [7:0]  flags;
      logic [15:0] hdr_len;
      logic [31:0] body_len;
      logic [15:0] message_type;
      logic [7:0]  content_type;
      logic [7:0]  reserved;
      logic [31:0] request_id;
   } frame_fields_type;

   typedef struct {
      frame_fields_type fields;
      int unsigned      body_count;
      logic [31:0]      body_pattern;
      rsp_word_type     want;
      string            label;
   } frame_row_type;

   frame_row_type directed_frames [2] = '{
      '{'{FRAME_MAGIC, FRAME_VERSION, 8'h00, HDR_LEN_FIELD, 32'd0,
          16'hFFFF, 8'hFF, 8'h00, 32'hFFFF_FFFF}, 0, 32'h0,
        '{KIND_HEADER, ERR_NONE, 16'hFFFF, 8'hFF, 32'hFFFF_FFFF, 25'd0, 8'h00, 1'b1},
        "empty body"},
      '{'{FRAME_MAGIC, FRAME_VERSION, 8'h00, HDR_LEN_FIELD, 32'd2,
          16'h0000, 8'h00, 8'h00, 32'h0000_0000}, 2, 32'h00FF_0000,
        '{KIND_HEADER, ERR_NONE, 16'h0000, 8'h00, 32'h0000_0000, 25'd2, 8'h00, 1'b0},
        "two byte body"}
   };

   frame_row_type bad_headers [8] = '{
      '{'{32'h4D43_4855, 8'h03, 8'h00, HDR_LEN_FIELD, 32'd0, 16'h1, 8'h1, 8'h00, 32'h1},
        0, 32'h0, '{KIND_ERROR, ERR_PROTOCOL, 16'h0, 8'h0, 32'h0, 25'd0, 8'h0, 1'b1},
        "bad magic and bad version"},
      '{'{32'h0000_0000, FRAME_VERSION, 8'h00, HDR_LEN_FIELD, 32'd0, 16'h1, 8'h1, 8'h00,
          32'h1}, 0, 32'h0, '{KIND_ERROR, ERR_PROTOCOL, 16'h0, 8'h0, 32'h0, 25'd0, 8'h0, 1'b1},
        "zero magic"},
      '{'{FRAME_MAGIC, 8'h00, 8'h01, HDR_LEN_FIELD, 32'd0, 16'h1, 8'h1, 8'h00, 32'h1},
        0, 32'h0, '{KIND_ERROR, ERR_VERSION, 16'h0, 8'h0, 32'h0, 25'd0, 8'h0, 1'b1},
        "bad version and nonzero flags"},
      '{'{FRAME_MAGIC, 8'hFF, 8'h00, HDR_LEN_FIELD, 32'd0, 16'h1, 8'h1, 8'h00, 32'h1},
        0, 32'h0, '{KIND_ERROR, ERR_VERSION, 16'h0, 8'h0, 32'h0, 25'd0, 8'h0, 1'b1},
        "version 255"},
      '{'{FRAME_MAGIC, FRAME_VERSION, 8'h00, 16'hFFFF, 32'd0, 16'h1, 8'h1, 8'h00, 32'h1},
        0, 32'h0, '{KIND_ERROR, ERR_PROTOCOL, 16'h0, 8'h0, 32'h0, 25'd0, 8'h0, 1'b1},
        "bad header length"},
      '{'{FRAME_MAGIC, FRAME_VERSION, 8'h80, HDR_LEN_FIELD, 32'd0, 16'h1, 8'h1, 8'h00, 32'h1},
        0, 32'h0, '{KIND_ERROR, ERR_PROTOCOL, 16'h0, 8'h0, 32'h0, 25'd0, 8'h0, 1'b1},
        "nonzero flags"},
      '{'{FRAME_MAGIC, FRAME_VERSION, 8'h00, HDR_LEN_FIELD, 32'd0, 16'h1, 8'h1, 8'hFF, 32'h1},
        0, 32'h0, '{KIND_ERROR, ERR_PROTOCOL, 16'h0, 8'h0, 32'h0, 25'd0, 8'h0, 1'b1},
        "nonzero reserved byte"},
      '{'{FRAME_MAGIC, FRAME_VERSION, 8'h00, HDR_LEN_FIELD, 32'hFFFF_FFFF, 16'h1, 8'h1, 8'h00,
          32'h1}, 0, 32'h0, '{KIND_ERROR, ERR_PROTOCOL, 16'h0, 8'h0, 32'h0, 25'd0, 8'h0, 1'b1},
        "body length over the limit"}
   };

   logic [LEN_W-1:0] limit_settings [NUM_PHASES-1] = '{
      25'd0, 25'd1, 25'd9, 25'h100_0000, 25'h1FF_FFFF, 25'h100_0001
   };

   logic             clock       = 1'b0;
   logic             reset       = 1'b1;
   logic             csr_wr_en   = 1'b0;
   logic [LEN_W-1:0] csr_wr_data = '0;

   lpfd_req_if req_bus ();
   lpfd_rsp_if rsp_bus ();

   length_prefixed_frame_deframer i_dut (
      .clock      (clock),
      .reset      (reset),
      .req        (req_bus),
      .rsp        (rsp_bus),
      .csr_wr_en  (csr_wr_en),
      .csr_wr_data(csr_wr_data)
   );

   always #5 clock = ~clock;

   // deframer state as seen from the byte stream
   phase_type        frame_phase = PH_HEADER;
   logic [7:0]       hdr_bytes [HDR_BYTES];
   int unsigned      hdr_count   = 0;
   logic [LEN_W-1:0] body_left   = '0;
   logic [LEN_W-1:0] body_limit  =
      LEN_W'((DEFAULT_MAX_BODY < HARD_MAX_BODY_DEF) ? DEFAULT_MAX_BODY : HARD_MAX_BODY_DEF);

   rsp_word_type pending_words [$];

   bit          req_burst      = 1'b0;
   bit          rsp_burst      = 1'b0;
   int unsigned cycle_count    = 0;
   int unsigned mismatches     = 0;
   int unsigned words_seen     = 0;
   int unsigned bytes_sent     = 0;
   int unsigned frames_sent    = 0;
   int unsigned limits_written = 0;

   function automatic bit deframe_byte(input logic [7:0] b, output rsp_word_type w);
      logic [31:0] blen;
      err_type     err;
      bit          have;
      w    = '0;
      have = 1'b0;
      case (frame_phase)
         PH_HEADER: begin
            hdr_bytes[hdr_count] = b;
            hdr_count++;
            if (hdr_count == HDR_BYTES) begin
               hdr_count = 0;
               have      = 1'b1;
               blen      = {hdr_bytes[8], hdr_bytes[9], hdr_bytes[10], hdr_bytes[11]};
               if ({hdr_bytes[0], hdr_bytes[1], hdr_bytes[2], hdr_bytes[3]} != FRAME_MAGIC)
                  err = ERR_PROTOCOL;
               else if (hdr_bytes[4] != FRAME_VERSION)
                  err = ERR_VERSION;
               else if ({hdr_bytes[6], hdr_bytes[7]} != HDR_LEN_FIELD)
                  err = ERR_PROTOCOL;
               else if (hdr_bytes[5] != 8'h00 || hdr_bytes[15] != 8'h00)
                  err = ERR_PROTOCOL;
               else if (blen > 32'(body_limit))
                  err = ERR_PROTOCOL;
               else
                  err = ERR_NONE;
               if (err != ERR_NONE) begin
                  frame_phase  = PH_DROP;
                  w.kind       = KIND_ERROR;
                  w.error_code = err;
                  w.last       = 1'b1;
               end else begin
                  w.kind         = KIND_HEADER;
                  w.message_type = {hdr_bytes[12], hdr_bytes[13]};
                  w.content_type = hdr_bytes[14];
                  w.request_id   = {hdr_bytes[16], hdr_bytes[17], hdr_bytes[18], hdr_bytes[19]};
                  w.body_length  = blen[LEN_W-1:0];
                  if (blen == 0) begin
                     w.last = 1'b1;
                  end else begin
                     body_left   = blen[LEN_W-1:0];
                     frame_phase = PH_BODY;
                  end
               end
            end
         end
         PH_BODY: begin
            have        = 1'b1;
            w.kind      = KIND_BODY;
            w.body_byte = b;
            if (body_left != 0)
               body_left--;
            if (body_left == 0) begin
               w.last      = 1'b1;
               frame_phase = PH_HEADER;
            end
         end
         default: ;
      endcase
      return have;
   endfunction

   function automatic string word_text(input rsp_word_type w);
      return $sformatf("kind=%0d err=%0d type=%h content=%h id=%h len=%0d byte=%h last=%b",
                       w.kind, w.error_code, w.message_type, w.content_type, w.request_id,
                       w.body_length, w.body_byte, w.last);
   endfunction

   function automatic void check_word();
      rsp_word_type got;
      rsp_word_type want;
      got = '{kind_type'(rsp_bus.kind), err_type'(rsp_bus.error_code), rsp_bus.message_type,
              rsp_bus.content_type, rsp_bus.request_id, rsp_bus.body_length,
              rsp_bus.body_byte, rsp_bus.last};
      words_seen++;
      if (pending_words.size() == 0) begin
         mismatches++;
         if (mismatches <= REPORT_MAX)
            $display("unexpected word: %s", word_text(got));
      end else begin
         want = pending_words.pop_front();
         if (got.kind !== want.kind || got.error_code !== want.error_code ||
             got.message_type !== want.message_type ||
             got.content_type !== want.content_type ||
             got.request_id !== want.request_id || got.body_length !== want.body_length ||
             got.body_byte !== want.body_byte || got.last !== want.last) begin
            mismatches++;
            if (mismatches <= REPORT_MAX) begin
               $display("word %0d expected %s", words_seen, word_text(want));
               $display("word %0d actual   %s", words_seen, word_text(got));
            end
         end
      end
   endfunction

   task automatic send_byte(input logic [7:0] b, input bit use_want, input rsp_word_type want);
      int unsigned  gap;
      rsp_word_type w;
      if ($urandom_range(0, 31) == 0)
         req_burst = !req_burst;
      gap = req_burst ? 0 : $urandom_range(0, 5);
      if (gap != 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid     <= 1'b1;
      req_bus.data_byte <= b;
      do @(posedge clock); while (!req_bus.ready);
      bytes_sent++;
      if (deframe_byte(b, w))
         pending_words.push_back(use_want ? want : w);
   endtask

   task automatic send_frame(input frame_fields_type f, input int unsigned body_count,
                             input logic [31:0] pattern, input bit patterned,
                             input bit use_want, input rsp_word_type want);
      logic [$bits(frame_fields_type)-1:0] raw;
      raw = f;
      for (int i = 0; i < HDR_BYTES; i++)
         send_byte(raw[$bits(frame_fields_type)-1-8*i -: 8], use_want && i == HDR_BYTES-1,
                   want);
      for (int i = 0; i < body_count; i++)
         send_byte(patterned ? pattern[31-8*(i%4) -: 8] : 8'($urandom), 1'b0, want);
      frames_sent++;
   endtask

   task automatic random_frame();
      frame_fields_type f;
      int unsigned      span;
      int unsigned      pick;
      f = '{FRAME_MAGIC, FRAME_VERSION, 8'h00, HDR_LEN_FIELD, 32'd0,
            16'($urandom), 8'($urandom), 8'h00, 32'($urandom)};
      span = (body_limit > 16) ? 16 : int'(body_limit);
      pick = $urandom_range(0, 19);
      if (body_limit == 0 || pick < 3)
         f.body_len = 0;
      else if (pick == 3)
         f.body_len = (body_limit > 200) ? $urandom_range(64, 200) : 32'(body_limit);
      else if (pick == 4)
         f.body_len = span;
      else
         f.body_len = $urandom_range(1, span);
      send_frame(f, f.body_len, 32'h0, 1'b0, 1'b0, '0);
   endtask

   task automatic settle_idle();
      req_bus.valid <= 1'b0;
      while (pending_words.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic set_body_limit(input logic [LEN_W-1:0] v);
      settle_idle();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= v;
      @(posedge clock);
      csr_wr_en  <= 1'b0;
      body_limit = (v > HARD_LIMIT) ? HARD_LIMIT : v;
      limits_written++;
   endtask

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("length_prefixed_frame_deframer test failed");
         $finish;
      end
   end

   initial begin
      int unsigned  gap;
      rsp_bus.ready <= 1'b0;
      while (reset !== 1'b0) @(posedge clock);
      forever begin
         if ($urandom_range(0, 31) == 0)
            rsp_burst = !rsp_burst;
         gap = rsp_burst ? 0 : $urandom_range(0, 5);
         if (gap != 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_bus.ready <= 1'b1;
         do @(posedge clock); while (!rsp_bus.valid);
         check_word();
      end
   end

   initial begin
      int unsigned budget;
      int unsigned pick;
      int unsigned drop_start;
      req_bus.valid     <= 1'b0;
      req_bus.data_byte <= 8'h00;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_frames[r])
         send_frame(directed_frames[r].fields, directed_frames[r].body_count,
                    directed_frames[r].body_pattern, 1'b1, 1'b1, directed_frames[r].want);

      for (int k = 0; k < NUM_PHASES; k++) begin
         set_body_limit((k == NUM_PHASES-1) ? LEN_W'($urandom_range(2, 4000))
                                            : limit_settings[k]);
         budget = bytes_sent + RANDOM_BYTES / NUM_PHASES;
         while (bytes_sent < budget) begin
            random_frame();
            if ($urandom_range(0, 9) == 0)
               settle_idle();
         end
      end

      // a failed header stops the stream for good, so it comes last
      pick = $urandom_range(0, 7);
      send_frame(bad_headers[pick].fields, 0, 32'h0, 1'b1, 1'b1, bad_headers[pick].want);
      drop_start = bytes_sent;
      repeat (40) send_byte(8'($urandom), 1'b0, '0);
      random_frame();

      req_bus.valid <= 1'b0;
      while (pending_words.size() != 0) @(posedge clock);
      repeat (2 * DRAIN_CYCLES) @(posedge clock);

      $display("covered %0d frames, %0d bytes, %0d result words, %0d body limits",
               frames_sent, bytes_sent, words_seen, limits_written);
      $display("closed with %s, then %0d bytes dropped",
               bad_headers[pick].label, bytes_sent - drop_start);
      if (mismatches == 0)
         $display("length_prefixed_frame_deframer test passed");
      else
         $display("length_prefixed_frame_deframer test failed");
      $finish;
   end

endmodule
